### sv/thit_pkg.sv
// Package for the topmost image hit test block: transaction types, codes,
// configuration layout and default sizes. No dependencies.
package thit_pkg;

  localparam int MAX_IMAGES_DEF = 16;
  localparam int MASK_MAX_W_DEF = 1024;
  localparam int MASK_MAX_H_DEF = 1024;
  localparam int FIFO_DEPTH     = 2;
  localparam int CFG_AW         = 4;

  localparam logic [1:0] MODE_ENTRY = 2'd0;
  localparam logic [1:0] MODE_MASK  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] REG_MASK_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MASK_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ENTRY,
    OP_MASK,
    OP_QUERY
  } op_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_MASK
  } back_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         entry_index;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic [15:0]        img_width;
    logic [15:0]        img_height;
    logic [15:0]        handle_in;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [9:0]         mask_col;
    logic [9:0]         mask_row;
    logic               mask_value;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] handle_out;
    logic [23:0] local_x;
    logic [23:0] local_y;
  } out_t;

  typedef struct packed {
    op_kind_t kind;
    in_t      item;
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic [4:0]  entry_count;
    logic [10:0] mask_width;
    logic [10:0] mask_height;
  } cfg_t;

endpackage

### sv/thit_front.sv
// Front end: takes input transactions and sorts them into queue operations.
// Depends on thit_pkg.
module thit_front #(
  parameter int MAX_IMAGES = thit_pkg::MAX_IMAGES_DEF,
  parameter int MASK_MAX_W = thit_pkg::MASK_MAX_W_DEF,
  parameter int MASK_MAX_H = thit_pkg::MASK_MAX_H_DEF
) (
  input  logic                   start,
  input  thit_pkg::in_t          in_data,
  input  thit_pkg::fifo_stat_t   stat,
  output logic                   push,
  output thit_pkg::op_t          op
);
  import thit_pkg::*;

  op_kind_t kind;

  always_comb begin
    case (in_data.mode)
      MODE_ENTRY: begin
        kind = (32'(in_data.entry_index) < 32'(MAX_IMAGES)) ? OP_ENTRY : OP_NONE;
      end
      MODE_MASK: begin
        kind = (32'(in_data.mask_col) < 32'(MASK_MAX_W) &&
                32'(in_data.mask_row) < 32'(MASK_MAX_H)) ? OP_MASK : OP_NONE;
      end
      MODE_QUERY: begin
        kind = OP_QUERY;
      end
      default: begin
        kind = OP_NONE;
      end
    endcase
  end

  assign op.kind = kind;
  assign op.item = in_data;
  assign push    = start && !stat.full && (kind != OP_NONE);

endmodule

### sv/thit_fifo.sv
// Short queue of operations between front and back end.
// Depends on thit_pkg.
module thit_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  thit_pkg::op_t        op_in,
  input  logic                 pop,
  output thit_pkg::op_t        op_out,
  output thit_pkg::fifo_stat_t stat
);
  import thit_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  op_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == FIFO_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == FIFO_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op_in;
    end
  end

  assign op_out     = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (32'(count_r) == FIFO_DEPTH);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count lost a push");
`endif

endmodule

### sv/thit_back.sv
// Back end: entry table, mask memory and the top-down query scan.
// Depends on thit_pkg.
module thit_back #(
  parameter int MAX_IMAGES = thit_pkg::MAX_IMAGES_DEF,
  parameter int MASK_MAX_W = thit_pkg::MASK_MAX_W_DEF,
  parameter int MASK_MAX_H = thit_pkg::MASK_MAX_H_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  thit_pkg::cfg_t       cfg,
  input  thit_pkg::op_t        op,
  input  thit_pkg::fifo_stat_t stat,
  output logic                 pop,
  output logic                 out_valid,
  output thit_pkg::out_t       out_data
);
  import thit_pkg::*;

  localparam int IDX_W      = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
  localparam int MASK_DEPTH = MASK_MAX_W * MASK_MAX_H;
  localparam int MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;

  logic signed [31:0] tcx [MAX_IMAGES];
  logic signed [31:0] tcy [MAX_IMAGES];
  logic [15:0]        tw  [MAX_IMAGES];
  logic [15:0]        th  [MAX_IMAGES];
  logic [15:0]        thd [MAX_IMAGES];
  logic               mask_mem [MASK_DEPTH];

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [31:0] px_r, px_nxt;
  logic signed [31:0] py_r, py_nxt;
  logic [23:0]        dx_r, dy_r, ly_r;
  logic [15:0]        hw_r, hh_r, hnd_r;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic               mrd_q;

  logic               tw_en, mwr_en, mrd_en, cand_load, ly_load;
  logic [IDX_W-1:0]   tw_idx, e_idx;
  logic [CNT_W-1:0]   e_full, n_cnt;
  logic [31:0]        n_full;
  logic [MASK_AW-1:0] mwr_addr, mrd_addr;
  logic [32:0]        dxs, dys;
  logic [15:0]        hm1;
  logic               x_ok, y_ok, ly_neg, cand;
  logic [23:0]        ly;
  logic [15:0]        col, row;
  logic               mask_on, mask_rng;

  assign n_full = (32'(cfg.entry_count) > 32'(MAX_IMAGES)) ? 32'(MAX_IMAGES)
                                                            : 32'(cfg.entry_count);
  assign n_cnt  = n_full[CNT_W-1:0];
  assign tw_idx = IDX_W'(32'(op.item.entry_index));
  assign mwr_addr = MASK_AW'(32'(op.item.mask_row) * MASK_MAX_W + 32'(op.item.mask_col));

  assign e_full = cnt_r - CNT_W'(1);
  assign e_idx  = e_full[IDX_W-1:0];

  assign dxs    = {px_r[31], px_r} - {tcx[e_idx][31], tcx[e_idx]};
  assign dys    = {py_r[31], py_r} - {tcy[e_idx][31], tcy[e_idx]};
  assign x_ok   = !dxs[32] && (dxs[31:24] == '0) && (dxs[23:0] < {tw[e_idx], 8'h00});
  assign y_ok   = !dys[32] && (dys[31:24] == '0) && (dys[23:0] < {th[e_idx], 8'h00});
  assign hm1    = th[e_idx] - 16'd1;
  assign ly_neg = (dys[23:8] == hm1) && (dys[7:0] != 8'h00);
  assign cand   = x_ok && y_ok && !ly_neg;

  assign ly       = {hh_r - 16'd1, 8'h00} - dy_r;
  assign col      = dx_r[23:8];
  assign row      = ly[23:8];
  assign mask_on  = ({5'd0, cfg.mask_width} == hw_r) && ({5'd0, cfg.mask_height} == hh_r);
  assign mask_rng = (32'(col) < 32'(MASK_MAX_W)) && (32'(row) < 32'(MASK_MAX_H));
  assign mrd_addr = MASK_AW'(32'(row) * MASK_MAX_W + 32'(col));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    tw_en         = 1'b0;
    mwr_en        = 1'b0;
    mrd_en        = 1'b0;
    cand_load     = 1'b0;
    ly_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!stat.empty) begin
          pop = 1'b1;
          case (op.kind)
            OP_ENTRY: begin
              tw_en = 1'b1;
            end
            OP_MASK: begin
              mwr_en = 1'b1;
            end
            OP_QUERY: begin
              px_nxt    = op.item.point_x;
              py_nxt    = op.item.point_y;
              cnt_nxt   = n_cnt;
              state_nxt = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt = e_full;
          if (cand) begin
            cand_load = 1'b1;
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        ly_load = 1'b1;
        if (!mask_on) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: 1'b1, handle_out: hnd_r, local_x: dx_r, local_y: ly};
          state_nxt     = S_IDLE;
        end else if (!mask_rng) begin
          state_nxt = S_SCAN;
        end else begin
          mrd_en    = 1'b1;
          state_nxt = S_MASK;
        end
      end
      S_MASK: begin
        if (mrd_q) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: 1'b1, handle_out: hnd_r, local_x: dx_r, local_y: ly_r};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    out_data_r <= out_data_nxt;
    if (cand_load) begin
      dx_r  <= dxs[23:0];
      dy_r  <= dys[23:0];
      hw_r  <= tw[e_idx];
      hh_r  <= th[e_idx];
      hnd_r <= thd[e_idx];
    end
    if (ly_load) begin
      ly_r <= ly;
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tcx[tw_idx] <= op.item.corner_x;
      tcy[tw_idx] <= op.item.corner_y;
      tw[tw_idx]  <= op.item.img_width;
      th[tw_idx]  <= op.item.img_height;
      thd[tw_idx] <= op.item.handle_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mwr_en) begin
      mask_mem[mwr_addr] <= op.item.mask_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mrd_en) begin
      mrd_q <= mask_mem[mrd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) != S_IDLE) else $error("result outside a query");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == S_IDLE) else $error("queue popped during a query");
  a_mask_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MASK |-> $past(state_r) == S_EVAL) else $error("mask check without read");
  a_miss_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cnt_r == '0) |=> out_valid_r && !out_data_r.found)
    else $error("scan end gave no miss");
`endif

endmodule

### sv/topmost_image_hit_test.sv
// Top level of the topmost image hit test: configuration registers, front end,
// operation queue and back end. Depends on thit_pkg, thit_front, thit_fifo, thit_back.
//
//   channel   handshake             payload
//   input     start / busy          in_data  (thit_pkg::in_t)
//   result    out_valid strobe      out_data (thit_pkg::out_t)
//   config    psel/penable/pready   paddr, pwdata, prdata
//
// A query in the back end scans the n entries in use from the top down; the entry
// scan is one entry per cycle while no candidate is being checked, an entry
// rejected by the mask resumes the scan, and mask reads go through one registered
// memory port. Table and mask writes wait for an idle back end. The queue holds two
// transactions; busy is high while it is full. Reset is synchronous, active
// low, and clears control state only. Results are strobes and cannot be stalled.
module topmost_image_hit_test #(
  parameter int MAX_IMAGES = thit_pkg::MAX_IMAGES_DEF,
  parameter int MASK_MAX_W = thit_pkg::MASK_MAX_W_DEF,
  parameter int MASK_MAX_H = thit_pkg::MASK_MAX_H_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  thit_pkg::in_t               in_data,
  output logic                        out_valid,
  output thit_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [thit_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import thit_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic       push, pop;
  op_t        push_op, head_op;
  fifo_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENTRY_COUNT: cfg_nxt.entry_count = pwdata[4:0];
        REG_MASK_WIDTH:  cfg_nxt.mask_width  = pwdata[10:0];
        REG_MASK_HEIGHT: cfg_nxt.mask_height = pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENTRY_COUNT: prdata = {27'd0, cfg_r.entry_count};
      REG_MASK_WIDTH:  prdata = {21'd0, cfg_r.mask_width};
      REG_MASK_HEIGHT: prdata = {21'd0, cfg_r.mask_height};
      default:         prdata = '0;
    endcase
  end

  assign busy = stat.full;

  thit_front #(
    .MAX_IMAGES(MAX_IMAGES),
    .MASK_MAX_W(MASK_MAX_W),
    .MASK_MAX_H(MASK_MAX_H)
  ) u_front (
    .start  (start),
    .in_data(in_data),
    .stat   (stat),
    .push   (push),
    .op     (push_op)
  );

  thit_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .op_in (push_op),
    .pop   (pop),
    .op_out(head_op),
    .stat  (stat)
  );

  thit_back #(
    .MAX_IMAGES(MAX_IMAGES),
    .MASK_MAX_W(MASK_MAX_W),
    .MASK_MAX_H(MASK_MAX_H)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .op       (head_op),
    .stat     (stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

### dv/testbench.sv
// Testbench for topmost_image_hit_test: queue-fed driver, strobe monitor and a
// scan predictor of the image table and mask. Depends on thit_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import thit_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 160;
  localparam int NUM_ENTRIES = MAX_IMAGES_DEF;
  localparam int MASK_CELLS = MASK_MAX_W_DEF * MASK_MAX_H_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  topmost_image_hit_test i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  in_t pending_ops[$];
  out_t expected_hits[$];
  out_t hit_seen;
  out_t hit_exp;
  int errors = 0;
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  // shadow of the block
  logic signed [31:0] tbl_cx[NUM_ENTRIES];
  logic signed [31:0] tbl_cy[NUM_ENTRIES];
  logic [15:0] tbl_w[NUM_ENTRIES];
  logic [15:0] tbl_h[NUM_ENTRIES];
  logic [15:0] tbl_handle[NUM_ENTRIES];
  bit mask_plane[MASK_CELLS];
  logic [4:0] cnt_reg = '0;
  logic [10:0] mw_reg = '0;
  logic [10:0] mh_reg = '0;

  // generator view, ahead of the shadow by the pending queue
  int gen_cx[NUM_ENTRIES];
  int gen_cy[NUM_ENTRIES];
  int gen_w[NUM_ENTRIES];
  int gen_h[NUM_ENTRIES];
  int gen_cnt = 0;
  int cur_mw = 0;
  int cur_mh = 0;
  bit gen_mask_done[MASK_CELLS];

  function automatic bit mask_bit(longint col, longint row);
    if (col >= MASK_MAX_W_DEF || row >= MASK_MAX_H_DEF) return 1'b0;
    return mask_plane[row * MASK_MAX_W_DEF + col];
  endfunction

  function automatic out_t predict_hit(input logic signed [31:0] px32,
                                       input logic signed [31:0] py32);
    out_t res;
    longint px, py, cx, cy, w, h, dx, dy, ly;
    int n;
    bit done;
    bit mbit;
    res = '0;
    done = 1'b0;
    px = px32;
    py = py32;
    n = (cnt_reg > NUM_ENTRIES) ? NUM_ENTRIES : int'(cnt_reg);
    for (int e = n - 1; e >= 0; e--) begin
      cx = tbl_cx[e];
      cy = tbl_cy[e];
      w = tbl_w[e];
      h = tbl_h[e];
      if (!done && cx <= px && px < cx + w * 256 && cy <= py && py < cy + h * 256) begin
        dx = px - cx;
        dy = py - cy;
        ly = (h - 1) * 256 - dy;
        if (ly >= 0) begin
          mbit = mask_bit(dx >>> 8, ly >>> 8);
          if (!(w == mw_reg && h == mh_reg) || mbit) begin
            res.found = 1'b1;
            res.handle_out = tbl_handle[e];
            res.local_x = dx[23:0];
            res.local_y = ly[23:0];
            done = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  function void track_item(in_t it);
    case (it.mode)
      MODE_ENTRY: begin
        tbl_cx[it.entry_index] = it.corner_x;
        tbl_cy[it.entry_index] = it.corner_y;
        tbl_w[it.entry_index] = it.img_width;
        tbl_h[it.entry_index] = it.img_height;
        tbl_handle[it.entry_index] = it.handle_in;
      end
      MODE_MASK: mask_plane[int'(it.mask_row) * MASK_MAX_W_DEF + int'(it.mask_col)] =
        it.mask_value;
      MODE_QUERY: expected_hits.insert(expected_hits.size(),
                                       predict_hit(it.point_x, it.point_y));
      default: ;
    endcase
  endfunction

  function void queue_item(in_t it);
    pending_ops.insert(pending_ops.size(), it);
  endfunction

  function automatic in_t random_item();
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  function void push_entry(int idx, int cx, int cy, int w, int h, int hnd);
    in_t it;
    it = random_item();
    it.mode = MODE_ENTRY;
    it.entry_index = idx[3:0];
    it.corner_x = cx;
    it.corner_y = cy;
    it.img_width = w[15:0];
    it.img_height = h[15:0];
    it.handle_in = hnd[15:0];
    gen_cx[idx] = cx;
    gen_cy[idx] = cy;
    gen_w[idx] = w;
    gen_h[idx] = h;
    queue_item(it);
  endfunction

  function void push_mask(int col, int row, bit val);
    in_t it;
    it = random_item();
    it.mode = MODE_MASK;
    it.mask_col = col[9:0];
    it.mask_row = row[9:0];
    it.mask_value = val;
    gen_mask_done[row * MASK_MAX_W_DEF + col] = 1'b1;
    queue_item(it);
  endfunction

  function void push_query(int px, int py);
    in_t it;
    it = random_item();
    it.mode = MODE_QUERY;
    it.point_x = px;
    it.point_y = py;
    queue_item(it);
  endfunction

  function void push_noise();
    in_t it;
    it = random_item();
    it.mode = MODE_UNUSED;
    queue_item(it);
  endfunction

  function automatic bit region_written(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (!gen_mask_done[r * MASK_MAX_W_DEF + c]) return 1'b0;
    return 1'b1;
  endfunction

  // an entry may only match the mask size once that mask area is loaded
  function automatic bit size_ok(int w, int h);
    if (w == 0 || h == 0) return 1'b1;
    if (w == MASK_MAX_W_DEF && h == MASK_MAX_H_DEF) return 1'b0;
    if (w != cur_mw || h != cur_mh) return 1'b1;
    return region_written(w, h);
  endfunction

  function void cover_mask(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (!gen_mask_done[r * MASK_MAX_W_DEF + c]) push_mask(c, r, $urandom_range(3, 0) != 0);
  endfunction

  function void gen_entry(int idx);
    int roll, w, h, cx, cy;
    roll = $urandom_range(99, 0);
    cx = int'($urandom_range(6144, 0)) - 3072;
    cy = int'($urandom_range(6144, 0)) - 3072;
    w = $urandom_range(24, 1);
    h = $urandom_range(24, 1);
    if (roll < 10) begin
      cx = int'($urandom);
      cy = int'($urandom);
      w = $urandom_range(65535, 1);
      h = $urandom_range(65535, 1);
    end else if (roll < 13) begin
      if (roll[0]) w = 0;
      else h = 0;
    end else if (roll < 55 && cur_mw > 0 && cur_mh > 0 && cur_mw <= 64 && cur_mh <= 64) begin
      w = cur_mw;
      h = cur_mh;
    end
    if (!size_ok(w, h)) h = (h == 65535) ? h - 1 : h + 1;
    push_entry(idx, cx, cy, w, h, $urandom_range(65535, 0));
  endfunction

  function automatic longint pick_offset(int size);
    int span;
    span = size * 256;
    case ($urandom_range(9, 0))
      0: return -1;
      1: return 0;
      2: return span - 1;
      3: return span;
      4: return (size == 0) ? 0 : longint'(span - 256) + $urandom_range(255, 1);
      default: return (size == 0) ? 0 : longint'($urandom_range(span - 1, 0));
    endcase
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function void gen_query();
    int roll, n, e;
    longint px, py;
    roll = $urandom_range(99, 0);
    n = (gen_cnt > NUM_ENTRIES) ? NUM_ENTRIES : gen_cnt;
    if (roll < 70) begin
      e = (n == 0) ? $urandom_range(NUM_ENTRIES - 1, 0) : $urandom_range(n - 1, 0);
      px = longint'(gen_cx[e]) + pick_offset(gen_w[e]);
      py = longint'(gen_cy[e]) + pick_offset(gen_h[e]);
    end else if (roll < 88) begin
      px = longint'($urandom_range(8192, 0)) - 4096;
      py = longint'($urandom_range(8192, 0)) - 4096;
    end else begin
      px = int'($urandom);
      py = int'($urandom);
    end
    push_query(clamp32(px), clamp32(py));
  endfunction

  function void random_op();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) gen_query();
    else if (roll < 78) gen_entry($urandom_range(NUM_ENTRIES - 1, 0));
    else if (roll < 95) begin
      if ($urandom_range(9, 0) < 7)
        push_mask($urandom_range(15, 0), $urandom_range(15, 0), $urandom_range(9, 0) < 6);
      else
        push_mask($urandom_range(1023, 0), $urandom_range(1023, 0), $urandom_range(1, 0));
    end else push_noise();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) track_item(in_data);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          in_data <= pending_ops.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(40, 1);
            case ($urandom_range(7, 0))
              0: gap_left = $urandom_range(80, 1);
              1, 2: gap_left = $urandom_range(10, 1);
              default: gap_left = 0;
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      hit_seen = out_data;
      if (expected_hits.size() == 0) begin
        $error("result with no query waiting: %h", hit_seen);
        errors++;
      end else begin
        hit_exp = expected_hits.pop_front();
        if (hit_seen.found !== hit_exp.found) begin
          $error("found: expected %0h actual %0h", hit_exp.found, hit_seen.found);
          errors++;
        end
        if (hit_seen.handle_out !== hit_exp.handle_out) begin
          $error("handle_out: expected %0h actual %0h", hit_exp.handle_out, hit_seen.handle_out);
          errors++;
        end
        if (hit_seen.local_x !== hit_exp.local_x) begin
          $error("local_x: expected %0h actual %0h", hit_exp.local_x, hit_seen.local_x);
          errors++;
        end
        if (hit_seen.local_y !== hit_exp.local_y) begin
          $error("local_y: expected %0h actual %0h", hit_exp.local_y, hit_seen.local_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic settle_idle();
    while (pending_ops.size() != 0 || start || expected_hits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_access(input logic [1:0] idx, input bit wr, input logic [31:0] val,
                            output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    cfg_access(idx, 1'b1, val, rd);
    case (idx)
      REG_ENTRY_COUNT: cnt_reg = val[4:0];
      REG_MASK_WIDTH: mw_reg = val[10:0];
      REG_MASK_HEIGHT: mh_reg = val[10:0];
      default: ;
    endcase
  endtask

  task automatic cfg_verify(input logic [1:0] idx, input logic [31:0] exp, input string name);
    logic [31:0] rd;
    cfg_access(idx, 1'b0, '0, rd);
    if (rd !== exp) begin
      $error("%s: expected %0h actual %0h", name, exp, rd);
      errors++;
    end
  endtask

  task automatic apply_settings(int cnt, int mw, int mh);
    cfg_write(REG_ENTRY_COUNT, cnt);
    cfg_write(REG_MASK_WIDTH, mw);
    cfg_write(REG_MASK_HEIGHT, mh);
    cfg_verify(REG_ENTRY_COUNT, {27'd0, cnt_reg}, "entry_count");
    cfg_verify(REG_MASK_WIDTH, {21'd0, mw_reg}, "mask_width");
    cfg_verify(REG_MASK_HEIGHT, {21'd0, mh_reg}, "mask_height");
    gen_cnt = cnt;
    cur_mw = mw;
    cur_mh = mh;
  endtask

  task automatic run_phase(int cnt, int mw, int mh, int n);
    if (mw > 0 && mh > 0 && mw <= 64 && mh <= 64) cover_mask(mw, mh);
    settle_idle();
    apply_settings(cnt, mw, mh);
    repeat (n) random_op();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, unused mode
    push_query(0, 0);
    push_noise();
    // overlapping entries, extreme corner and size, zero width
    push_entry(0, -1024, -512, 8, 4, 16'hffff);
    push_entry(1, 32'h7fffff00, 32'h80000000, 65535, 65535, 16'h1234);
    push_entry(2, 0, 0, 0, 5, 16'haaaa);
    push_entry(3, 256, 256, 2, 2, 16'h5555);
    push_mask(0, 0, 1'b1);
    push_mask(1, 0, 1'b0);
    push_mask(0, 1, 1'b1);
    push_mask(1, 1, 1'b1);
    push_mask(1023, 1023, 1'b1);
    settle_idle();
    apply_settings(4, 2, 2);
    cfg_write(REG_SPARE, $urandom);
    push_query(522, 300);
    push_query(300, 300);
    push_query(300, 712);
    push_query(32'h7fffff00, 32'h80000000);
    push_query(32'h7fffffff, -2130706689);
    push_query(-1025, 0);
    push_query(-1024, -512);
    push_query(1023, 256);
    push_query(1023, 257);
    push_query(1024, 0);
    push_query(0, 256);
    push_query(32'h80000000, 32'h7fffffff);

    for (int i = 0; i < NUM_ENTRIES; i++) gen_entry(i);
    run_phase(16, 4, 4, 60);
    run_phase(31, 8, 8, 60);
    run_phase(1, 1, 1, 45);
    run_phase(16, 1024, 1024, 55);
    run_phase(0, 0, 0, 20);
    run_phase(9, 3, 5, 60);
    run_phase(16, 0, 7, 45);
    run_phase($urandom_range(16, 1), $urandom_range(8, 1), $urandom_range(8, 1), 60);
    run_phase(16, 7, 2, 60);

    settle_idle();
    if (expected_hits.size() != 0) begin
      $error("%0d results never arrived", expected_hits.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
